[hdl/bhe_pkg.sv]
// Package for the byte histogram engine: sizes, command codes, FSM state type
// and the control/status structs between controller and datapath.
// No dependencies.
package bhe_pkg;

  localparam int NUM_BINS    = 256;
  localparam int ADDR_W      = $clog2(NUM_BINS);
  localparam int COUNT_WIDTH = 32;
  localparam int IDX_W       = 8;   // sample_or_bin / bin_index
  localparam int OUT_COUNT_W = 32;  // bin_count field
  localparam int CMD_W       = 2;

  localparam logic [COUNT_WIDTH-1:0] COUNT_TOP = '1;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_COUNT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // take the input transaction, launch the bin read
    logic commit;  // update the bin and load the result register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;  // result register empty or drained this cycle
  } dp_status_t;

endpackage

[hdl/bhe_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bhe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/bhe_ctrl.sv]
// Controller FSM for the byte histogram engine: accept, then execute.
// Depends on bhe_pkg.
module bhe_ctrl
  import bhe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_EXEC: begin
        cmd.commit = status.out_free;
      end
      default: ;
    endcase
  end

endmodule

[hdl/bhe_datapath.sv]
// Datapath: item registers, bin RAM with per-bin valid flags, saturating
// increment and the result register. Depends on bhe_pkg and bhe_ram.
module bhe_datapath
  import bhe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  ctrl_cmd_t              cmd,
  output dp_status_t             status,
  input  logic [CMD_W-1:0]       in_command,
  input  logic [IDX_W-1:0]       in_sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [IDX_W-1:0]       out_index,
  output logic [OUT_COUNT_W-1:0] out_count,
  output logic                   out_sat
);

  logic [CMD_W-1:0]       cmd_q;
  logic [IDX_W-1:0]       idx_q;
  logic [NUM_BINS-1:0]    bin_valid;
  logic [ADDR_W-1:0]      addr_q;
  logic [COUNT_WIDTH-1:0] rd_data;
  logic [COUNT_WIDTH-1:0] old_count;
  logic [COUNT_WIDTH-1:0] new_count;
  logic                   in_range;
  logic                   is_clear;
  logic                   is_count;
  logic                   at_top;
  logic                   bump;

  assign addr_q   = ADDR_W'(idx_q);
  assign in_range = 32'(idx_q) < NUM_BINS;
  assign is_clear = cmd_q == CMD_CLEAR;
  assign is_count = cmd_q == CMD_COUNT;

  // bins never written since reset/clear read as zero
  assign old_count = bin_valid[addr_q] ? rd_data : '0;
  assign at_top    = old_count == COUNT_TOP;
  assign bump      = cmd.commit && is_count && in_range && !at_top;
  assign new_count = (is_count && !at_top) ? old_count + 1'b1 : old_count;

  assign status.out_free = !out_valid || out_ready;

  bhe_ram #(
    .WIDTH(COUNT_WIDTH),
    .DEPTH(NUM_BINS)
  ) u_bins (
    .clk  (clk),
    .we   (bump),
    .waddr(addr_q),
    .wdata(new_count),
    .re   (cmd.load),
    .raddr(ADDR_W'(in_sample)),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q <= in_command;
      idx_q <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_valid <= '0;
    end else if (cmd.commit && is_clear) begin
      bin_valid <= '0;
    end else if (bump) begin
      bin_valid[addr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (is_clear || !in_range) begin
        out_index <= is_clear ? '0 : idx_q;
        out_count <= '0;
        out_sat   <= 1'b0;
      end else begin
        out_index <= idx_q;
        out_count <= OUT_COUNT_W'(new_count);
        out_sat   <= new_count == COUNT_TOP;
      end
    end
  end

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  a_clear_flags: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && is_clear) |=> (bin_valid == '0))
    else $error("clear left a bin valid");

  a_sat_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_sat) |-> (out_count == OUT_COUNT_W'(COUNT_TOP)))
    else $error("saturated flag without top count");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !cmd.load)
    else $error("second load during execute");

endmodule

[hdl/byte_histogram_engine_core.sv]
// Byte histogram engine, top level: 256 saturating 32-bit bin counters.
// Each transaction reads its bin from RAM, then updates it and loads the
// result register once that register is free. A new transaction is taken
// only after the previous one commits, as the single bin RAM is read and
// then written per item. Clear drops all per-bin valid flags at once.
// Reset (rst, synchronous): all bins read zero right away, no result pending.
module byte_histogram_engine_core
  import bhe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] sample_or_bin
  input  logic [1:0]  s_tuser,   // [1:0] command
  // result channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [7:0] bin_index, [39:8] bin_count
  output logic        m_tuser    // [0] count_saturated
);

  ctrl_cmd_t              cmd;
  dp_status_t             status;
  logic [IDX_W-1:0]       out_index;
  logic [OUT_COUNT_W-1:0] out_count;

  // FSM: idle accepts one transaction, execute commits it once the
  // result register can take it.
  bhe_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .status  (status),
    .cmd     (cmd)
  );

  // Bin storage plus result register; the result register decouples the
  // output side so a waiting result does not block the next accept.
  bhe_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_command(s_tuser),
    .in_sample (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_index (out_index),
    .out_count (out_count),
    .out_sat   (m_tuser)
  );

  assign m_tdata = {out_count, out_index};

endmodule

[tb/byte_histogram_engine_core_tb.sv]
// Self-checking testbench for byte_histogram_engine_core: drives clear, count and
// read transactions and checks every result against an in-bench histogram model.
// Depends on bhe_pkg and the core RTL only.
module byte_histogram_engine_core_tb
  import bhe_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;  // cycles with no transaction on either side
  localparam int DRAIN_CYCLES = 10;   // idle margin before the end of the run
  localparam int HOLD_OFF_LEN = 200;  // long receiver hold-off for back-pressure
  localparam logic [CMD_W-1:0] CMD_ALIAS = 2'd3;  // unused code, behaves as read

  // one expected result transaction
  typedef struct {
    logic [IDX_W-1:0]       idx;
    logic [OUT_COUNT_W-1:0] count;
    logic                   sat;
  } bin_result_t;

  // Histogram model plus queue of pending results.
  class histogram_scoreboard;
    logic [COUNT_WIDTH-1:0] bin_tally [NUM_BINS];
    bin_result_t            expected_bins [$];
    int                     mismatches;

    function new();
      mismatches = 0;
      foreach (bin_tally[i]) bin_tally[i] = '0;
    endfunction

    function int pending();
      return expected_bins.size();
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t MISMATCH %s: got %0h expected %0h", $realtime, what, got, want);
      mismatches++;
    endtask

    // accepted input transaction: update the bins, queue the result
    function void predict_item(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] sample);
      bin_result_t r;
      r = '{idx: '0, count: '0, sat: 1'b0};
      if (cmd == CMD_CLEAR) begin
        foreach (bin_tally[i]) bin_tally[i] = '0;
      end else begin
        r.idx = sample;
        if (int'(sample) < NUM_BINS) begin
          if (cmd == CMD_COUNT && bin_tally[sample] != COUNT_TOP)
            bin_tally[sample] = bin_tally[sample] + 1'b1;
          r.count = OUT_COUNT_W'(bin_tally[sample]);
          r.sat   = (bin_tally[sample] == COUNT_TOP);
        end
      end
      expected_bins.push_back(r);
    endfunction

    task check_result(logic [39:0] data, logic user);
      bin_result_t want;
      if (expected_bins.size() == 0) begin
        report_mismatch("unexpected result", {24'd0, data}, 64'd0);
      end else begin
        want = expected_bins.pop_front();
        if (data[7:0] !== want.idx)
          report_mismatch("bin_index", 64'(data[7:0]), 64'(want.idx));
        if (data[39:8] !== want.count)
          report_mismatch("bin_count", 64'(data[39:8]), 64'(want.count));
        if (user !== want.sat)
          report_mismatch("count_saturated", 64'(user), 64'(want.sat));
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] sample_or_bin
  logic [1:0]  s_tuser;   // [1:0] command
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // [7:0] bin_index, [39:8] bin_count
  logic        m_tuser;   // [0] count_saturated

  histogram_scoreboard sb = new();

  int src_idle_pct  = 0;   // chance per cycle that the sender holds off
  int snk_stall_pct = 0;   // chance per cycle that the receiver stalls
  int hold_len      = 0;   // forced receiver hold-off, counted down by receiver
  int idle_cycles   = 0;

  byte_histogram_engine_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Receiver: ready changes on the falling edge. A pending hold-off wins over
  // the random stall pattern.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        m_tready = 1'b0;
        hold_len--;
      end else begin
        m_tready = ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // Result monitor: sample at the rising edge.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tdata, m_tuser);
  end

  // Watchdog: ends the run if no transaction moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Offer one item, entered and left at a falling edge. Random gaps come first,
  // so valid only drops when the sender really idles.
  task send_item(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] sample);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = cmd;
    s_tdata  = sample;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.predict_item(cmd, sample);
    @(negedge clk);
  endtask

  // Sender pause: nothing offered until every queued result has come back.
  task wait_drained();
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Random traffic: mostly counts, concentrated on a few bins so counts grow,
  // plus reads, the unused code and an occasional clear.
  task send_random(int n);
    int r;
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] sample;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 2)       cmd = CMD_CLEAR;
      else if (r < 8)  cmd = CMD_ALIAS;
      else if (r < 32) cmd = CMD_READ;
      else             cmd = CMD_COUNT;
      if ($urandom_range(1) == 0)
        sample = ($urandom_range(1) == 0) ? IDX_W'($urandom_range(7))
                                          : IDX_W'($urandom_range(255, 248));
      else
        sample = IDX_W'($urandom);
      send_item(cmd, sample);
    end
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = CMD_CLEAR;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: edge bins, every command, clear result, unused code as read.
    // Saturation needs 2^32 - 1 counts and is left to the model's logic.
    send_item(CMD_CLEAR, 8'h00);
    send_item(CMD_COUNT, 8'h00);
    send_item(CMD_COUNT, 8'h00);
    send_item(CMD_COUNT, 8'hFF);
    send_item(CMD_COUNT, 8'hFF);
    send_item(CMD_COUNT, 8'hFF);
    send_item(CMD_READ,  8'h00);
    send_item(CMD_READ,  8'hFF);
    send_item(CMD_READ,  8'h01);
    send_item(CMD_ALIAS, 8'hFF);
    send_item(CMD_ALIAS, 8'h07);
    send_item(CMD_COUNT, 8'h55);
    send_item(CMD_COUNT, 8'hAA);
    send_item(CMD_READ,  8'h55);
    send_item(CMD_READ,  8'hAA);
    send_item(CMD_CLEAR, 8'hFF);   // clear ignores the byte, reports bin 0
    send_item(CMD_READ,  8'hFF);
    send_item(CMD_READ,  8'h00);
    send_item(CMD_COUNT, 8'h80);
    send_item(CMD_READ,  8'h80);
    send_item(CMD_ALIAS, 8'h80);
    wait_drained();

    // Phase 1: back to back on both sides.
    src_idle_pct = 0;  snk_stall_pct = 0;
    send_random(460);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering: the core must
    // fill up and drop s_tready.
    @(posedge clk);
    hold_len = HOLD_OFF_LEN;
    @(negedge clk);
    for (int i = 0; i < 24; i++) send_item(CMD_COUNT, IDX_W'($urandom_range(3)));
    wait_drained();

    // Phase 2: sender idles.
    src_idle_pct = 46; snk_stall_pct = 0;
    send_random(460);
    wait_drained();

    // Phase 3: receiver stalls.
    src_idle_pct = 0;  snk_stall_pct = 46;
    send_random(460);
    wait_drained();

    // Phase 4: both sides idle.
    src_idle_pct = 24; snk_stall_pct = 24;
    send_random(460);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[files.f]
hdl/bhe_pkg.sv
hdl/bhe_ram.sv
hdl/bhe_ctrl.sv
hdl/bhe_datapath.sv
hdl/byte_histogram_engine_core.sv
tb/byte_histogram_engine_core_tb.sv
